FILE: design/cbb_pkg.sv
// Shared types, widths and codes for the clamped box blur unit.
// Used by cbb_ram users, cbb_div and clamped_box_blur_unit; no dependencies.
`timescale 1ns / 1ps

package cbb_pkg;

  // Largest integer of two, evaluated at elaboration
  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Frame store size
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  // Fixed field widths
  localparam int PIX_BITS      = 8;
  localparam int COORD_BITS    = 8;
  localparam int CFG_DIM_BITS  = 9;
  localparam int RADIUS_BITS   = 8;
  localparam int CFG_DATA_BITS = 9;
  localparam int CFG_IDX_BITS  = 2;
  localparam int NUM_CH        = 3;
  localparam int CH_BITS       = 2;
  localparam int PIXEL_BITS    = NUM_CH * PIX_BITS;

  // Derived widths
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS   = max_int(1, $clog2(STORE_DEPTH));
  localparam int SPAN_BITS   = max_int(max_int($clog2(MAX_WIDTH + 1), $clog2(MAX_HEIGHT + 1)),
                                       max_int(COORD_BITS + 1, CFG_DIM_BITS));
  localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1);
  localparam int SUM_BITS    = CNT_BITS + PIX_BITS;
  localparam int STEP_BITS   = $clog2(PIX_BITS);

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLUR_RADIUS  = 2'd2;

  // Configuration reset values
  localparam logic [CFG_DIM_BITS-1:0] FRAME_WIDTH_RESET  = 9'd256;
  localparam logic [CFG_DIM_BITS-1:0] FRAME_HEIGHT_RESET = 9'd256;
  localparam logic [RADIUS_BITS-1:0]  BLUR_RADIUS_RESET  = 8'd1;

  // Command and status codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_RANGE = 1'b1;

  // Channel slots, red first (red sits in the top byte of a stored pixel)
  localparam logic [CH_BITS-1:0] CH_RED   = 2'd0;
  localparam logic [CH_BITS-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_BITS-1:0] CH_BLUE  = 2'd2;

  // Query sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_WALK,
    S_DRAIN,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  // Divider request and response
  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] dividend;
    logic [CNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PIX_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: design/cbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the frame store of the clamped box blur unit.
`timescale 1ns / 1ps

module cbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/cbb_div.sv
// Restoring divider for one channel mean: one quotient bit per cycle.
// Depends on cbb_pkg; quotient is known to fit in one pixel byte.
`timescale 1ns / 1ps

module cbb_div (
  input  logic              clk,
  input  logic              rst,
  input  cbb_pkg::div_req_t req,
  output cbb_pkg::div_rsp_t rsp
);
  import cbb_pkg::*;

  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(PIX_BITS - 1);

  logic                 busy;
  logic                 done;
  logic [STEP_BITS-1:0] step;
  logic [SUM_BITS-1:0]  rem;
  logic [SUM_BITS-1:0]  dsr;
  logic [PIX_BITS-1:0]  quot;

  // Track busy and pulse done after the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Compare and subtract the shifted divisor, one bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.dividend;
      dsr  <= SUM_BITS'(req.divisor) << (PIX_BITS - 1);
      quot <= '0;
      step <= '0;
    end else if (busy) begin
      if (rem >= dsr) begin
        rem  <= rem - dsr;
        quot <= {quot[PIX_BITS-2:0], 1'b1};
      end else begin
        quot <= {quot[PIX_BITS-2:0], 1'b0};
      end
      dsr  <= dsr >> 1;
      step <= step + 1'b1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

FILE: design/clamped_box_blur_unit.sv
// Top level of the clamped box blur unit: sequencer, window walk and accumulators.
// Depends on cbb_pkg, cbb_ram (frame store) and cbb_div (mean divider).
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries a command with col and row.
//   A load writes one RGB pixel into the frame store and gives no
//   result. A query gives one result on the output channel
//   (out_valid/out_ready): the mean of each color over the window of
//   blur_radius pixels around the pixel, clipped to the frame, truncated.
//   A query outside the configured frame returns zeros with status set.
//   Sequence: for a query in the frame, the frame store read port walks
//   the clipped window one pixel a cycle, then one divider is reused for
//   the three channels in turn. A query outside the frame goes from setup
//   straight to its result. in_ready is low while a query is in work, so
//   a new command waits until that query's result is in the output
//   register; loads go one a cycle while no query is in work.
//   Reset: configuration returns to a 256 x 256 frame with radius 1; the
//   frame store is not cleared and must be loaded before it is queried.
//   Stall: a finished result sits in the output register; loads are still
//   accepted meanwhile, and a following query waits to replace the held one.
//   Configuration must be written only while idle; the block does not check.
module clamped_box_blur_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cbb_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
  input  logic [cbb_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [cbb_pkg::COORD_BITS-1:0]      col,
  input  logic [cbb_pkg::COORD_BITS-1:0]      row,
  input  logic [cbb_pkg::PIX_BITS-1:0]        in_red,
  input  logic [cbb_pkg::PIX_BITS-1:0]        in_green,
  input  logic [cbb_pkg::PIX_BITS-1:0]        in_blue,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cbb_pkg::PIX_BITS-1:0]        out_red,
  output logic [cbb_pkg::PIX_BITS-1:0]        out_green,
  output logic [cbb_pkg::PIX_BITS-1:0]        out_blue,
  output logic                                status
);
  import cbb_pkg::*;

  typedef logic [SPAN_BITS-1:0] span_t;

  // Configuration registers
  logic [CFG_DIM_BITS-1:0] frame_width;
  logic [CFG_DIM_BITS-1:0] frame_height;
  logic [RADIUS_BITS-1:0]  blur_radius;

  // Sequencer
  state_t state;
  state_t state_next;
  logic   walk_en;
  logic   out_load;

  // Query coordinates and window bounds
  logic [COORD_BITS-1:0] q_col;
  logic [COORD_BITS-1:0] q_row;
  span_t                 x;
  span_t                 y;
  span_t                 left;
  span_t                 right;
  span_t                 bottom;

  // Setup arithmetic
  span_t eff_w;
  span_t eff_h;
  span_t r_span;
  span_t col_span;
  span_t row_span;
  span_t col_hi;
  span_t row_hi;
  span_t left_c;
  span_t right_c;
  span_t top_c;
  span_t bottom_c;
  logic  oob;

  // Accumulation and results
  logic                    acc_valid;
  logic [SUM_BITS-1:0]     sum [NUM_CH];
  logic [CNT_BITS-1:0]     pix_count;
  logic [CH_BITS-1:0]      ch;
  logic [PIX_BITS-1:0]     res [NUM_CH];
  logic                    res_status;

  // Frame store ports
  logic                    ram_we;
  logic [ADDR_BITS-1:0]    ram_waddr;
  logic [PIXEL_BITS-1:0]   ram_wdata;
  logic [ADDR_BITS-1:0]    ram_raddr;
  logic [PIXEL_BITS-1:0]   ram_rdata;

  // Divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      blur_radius  <= BLUR_RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_wdata[CFG_DIM_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_wdata[CFG_DIM_BITS-1:0];
        CFG_BLUR_RADIUS:  blur_radius  <= cfg_wdata[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Store loads that fall inside the frame store
  assign ram_we = in_valid && in_ready && (command == CMD_LOAD)
                  && (span_t'(col) < span_t'(MAX_WIDTH))
                  && (span_t'(row) < span_t'(MAX_HEIGHT));
  assign ram_waddr = ADDR_BITS'(row) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(col);
  assign ram_wdata = {in_red, in_green, in_blue};
  assign ram_raddr = ADDR_BITS'(y) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(x);

  cbb_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clip the window to the effective frame
  always_comb begin
    eff_w    = (span_t'(frame_width) > span_t'(MAX_WIDTH))
               ? span_t'(MAX_WIDTH) : span_t'(frame_width);
    eff_h    = (span_t'(frame_height) > span_t'(MAX_HEIGHT))
               ? span_t'(MAX_HEIGHT) : span_t'(frame_height);
    r_span   = span_t'(blur_radius);
    col_span = span_t'(q_col);
    row_span = span_t'(q_row);
    oob      = (col_span >= eff_w) || (row_span >= eff_h);
    col_hi   = col_span + r_span;
    row_hi   = row_span + r_span;
    left_c   = (col_span > r_span) ? col_span - r_span : '0;
    top_c    = (row_span > r_span) ? row_span - r_span : '0;
    right_c  = (col_hi > eff_w - 1'b1) ? eff_w - 1'b1 : col_hi;
    bottom_c = (row_hi > eff_h - 1'b1) ? eff_h - 1'b1 : row_hi;
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && command == CMD_QUERY) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        state_next = oob ? S_DONE : S_WALK;
      end
      S_WALK: begin
        if (x == right && y == bottom) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:     state_next = S_DIV_START;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = (ch == CH_BLUE) ? S_DONE : S_DIV_START;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready         = (state == S_IDLE);
    walk_en          = (state == S_WALK);
    out_load         = (state == S_DONE) && (!out_valid || out_ready);
    div_req.start    = (state == S_DIV_START);
    div_req.dividend = sum[ch];
    div_req.divisor  = pix_count;
  end

  cbb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Mark read data that belongs to the window
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else begin
      acc_valid <= walk_en;
    end
  end

  // Query datapath: latch, set up bounds, walk, accumulate, collect quotients
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && command == CMD_QUERY) begin
      q_col <= col;
      q_row <= row;
    end
    if (state == S_SETUP) begin
      left       <= left_c;
      right      <= right_c;
      bottom     <= bottom_c;
      x          <= left_c;
      y          <= top_c;
      pix_count  <= '0;
      ch         <= CH_RED;
      res_status <= oob ? STAT_RANGE : STAT_OK;
      for (int c = 0; c < NUM_CH; c++) begin
        sum[c] <= '0;
        res[c] <= '0;
      end
    end
    if (walk_en) begin
      if (x == right) begin
        x <= left;
        y <= y + 1'b1;
      end else begin
        x <= x + 1'b1;
      end
    end
    if (acc_valid) begin
      pix_count <= pix_count + 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        sum[c] <= sum[c] + SUM_BITS'(ram_rdata[PIX_BITS*(NUM_CH-c)-1 -: PIX_BITS]);
      end
    end
    if (state == S_DIV_WAIT && div_rsp.done) begin
      res[ch] <= div_rsp.quotient;
      ch      <= ch + 1'b1;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red   <= res[CH_RED];
      out_green <= res[CH_GREEN];
      out_blue  <= res[CH_BLUE];
      status    <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_START |-> pix_count != '0)
    else $error("divide started with an empty window");

  a_acc_after_walk: assert property (@(posedge clk) disable iff (rst)
    acc_valid |-> $past(state) == S_WALK)
    else $error("accumulation outside the window walk");

  a_walk_in_window: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> (x >= left) && (x <= right) && (y <= bottom))
    else $error("walk address left the clipped window");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");
`endif

endmodule
